/* sv/nak_loss_list_membership_macros.svh */
// Assertion macros for the loss list RTL.
`ifndef NAK_LOSS_LIST_MEMBERSHIP_MACROS_SVH
`define NAK_LOSS_LIST_MEMBERSHIP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NLL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NLL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/nll_pkg.sv */
// Types, codes and sizes for the NAK loss list membership block.
package nll_pkg;

    localparam int MAX_WORDS = 64;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int COUNT_W   = $clog2(MAX_WORDS + 1);
    localparam int WORD_W    = 32;
    localparam int SEQ_W     = 31;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_SINGLE = 3'd1;
    localparam logic [2:0] CMD_RANGE  = 3'd2;
    localparam logic [2:0] CMD_RAW    = 3'd3;
    localparam logic [2:0] CMD_QUERY  = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SECOND,
        S_WALK
    } state_t;

    typedef struct packed {
        logic [2:0]        command;
        logic [WORD_W-1:0] value_a;
        logic [SEQ_W-1:0]  value_b;
    } req_item_t;

    typedef struct packed {
        logic               found;
        logic [1:0]         status;
        logic [COUNT_W-1:0] word_count;
    } rsp_item_t;

endpackage

/* sv/nll_if.sv */
// Valid/ready channels for command items and result items.
interface nll_req_if
    import nll_pkg::*;
();
    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nll_rsp_if
    import nll_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/nll_match.sv */
// Tests a query number against one stored word, as a range when it opens one.
module nll_match
    import nll_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [WORD_W-1:0] next_word,
    input  logic              has_next,
    input  logic [SEQ_W-1:0]  seq,
    output logic              hit
);

    logic [SEQ_W-1:0] lo;
    logic [SEQ_W-1:0] hi;
    logic             ge_lo;
    logic             le_hi;

    assign lo    = word[SEQ_W-1:0];
    assign hi    = next_word[SEQ_W-1:0];
    assign ge_lo = (seq >= lo);
    assign le_hi = (seq <= hi);

    always_comb
    begin
        if (word[WORD_W-1] && has_next)
        begin
            // a range whose first exceeds its last wraps past the top
            if (lo <= hi)
                hit = ge_lo && le_hi;
            else
                hit = ge_lo || le_hi;
        end
        else
        begin
            hit = (lo == seq);
        end
    end

endmodule

/* sv/nak_loss_list_membership.sv */
// NAK loss list membership: an ordered list of up to MAX_WORDS 32-bit loss
// words in one synchronous RAM, with clear, add single, add range, add raw and
// query commands, one result item per command item. Clear, add single, add raw
// and refused or out-of-range commands are answered from the idle state; add
// range writes its second word in a second state, since both of its words go
// through the single RAM write port. A query walks the stored words in order
// through the single RAM read port; a query on an empty list is answered from
// the idle state. A result waits in the output register and the next item is
// taken in the cycle that result leaves.
`include "nak_loss_list_membership_macros.svh"

module nak_loss_list_membership
    import nll_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    nll_req_if.sink    req,
    nll_rsp_if.source  rsp
);

    state_t             state_reg;
    state_t             state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic [SEQ_W-1:0]   last_reg;
    logic [SEQ_W-1:0]   last_next;
    logic [SEQ_W-1:0]   seq_reg;
    logic [SEQ_W-1:0]   seq_next;
    logic [COUNT_W-1:0] rd_idx_reg;
    logic [COUNT_W-1:0] rd_idx_next;
    logic               rvalid_reg;
    logic               rvalid_next;
    logic [WORD_W-1:0]  prev_reg;
    logic [WORD_W-1:0]  prev_next;
    logic               have_prev_reg;
    logic               have_prev_next;
    logic               hit_reg;
    logic               hit_next;
    rsp_item_t          out_reg;
    rsp_item_t          out_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [WORD_W-1:0]  mem [MAX_WORDS];
    logic [WORD_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic               accept;
    logic               full_one;
    logic               full_two;
    logic               go_second;
    logic               go_walk;
    logic               issue;
    logic               walk_done;
    logic               match_hit;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign count_inc = count_reg + COUNT_W'(1);
    assign full_one  = (count_reg == COUNT_W'(MAX_WORDS));
    assign full_two  = (count_reg > COUNT_W'(MAX_WORDS - 2));

    assign go_second = accept && (req.data.command == CMD_RANGE)
                       && !req.data.value_a[WORD_W-1] && !full_two;
    assign go_walk   = accept && (req.data.command == CMD_QUERY)
                       && !req.data.value_a[WORD_W-1] && (count_reg != '0);

    assign issue     = (state_reg == S_WALK) && (rd_idx_reg < count_reg);
    assign walk_done = (state_reg == S_WALK) && !rvalid_reg && !issue;

    // judge the held word once its successor is known, or alone at the end
    nll_match u_match (
        .word      (prev_reg),
        .next_word (rd_data_reg),
        .has_next  (rvalid_reg),
        .seq       (seq_reg),
        .hit       (match_hit)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go_second)
                    state_next = S_SECOND;
                else if (go_walk)
                    state_next = S_WALK;
            end
            S_SECOND:
            begin
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (walk_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        last_next      = last_reg;
        seq_next       = seq_reg;
        rd_idx_next    = rd_idx_reg;
        rvalid_next    = 1'b0;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        hit_next       = hit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[ADDR_W-1:0];
        mem_wdata      = req.data.value_a;
        mem_re         = 1'b0;
        mem_raddr      = rd_idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next.found  = 1'b0;
                    out_next.status = STAT_OK;
                    out_valid_next  = 1'b1;
                    case (req.data.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_SINGLE:
                        begin
                            if (req.data.value_a[WORD_W-1])
                                out_next.status = STAT_RANGE;
                            else if (full_one)
                                out_next.status = STAT_FULL;
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_inc;
                            end
                        end
                        CMD_RANGE:
                        begin
                            if (req.data.value_a[WORD_W-1])
                                out_next.status = STAT_RANGE;
                            else if (full_two)
                                out_next.status = STAT_FULL;
                            else
                            begin
                                // write the opening word now, the last next cycle
                                mem_we         = 1'b1;
                                mem_wdata      = {1'b1, req.data.value_a[SEQ_W-1:0]};
                                last_next      = req.data.value_b;
                                out_valid_next = 1'b0;
                            end
                        end
                        CMD_RAW:
                        begin
                            if (full_one)
                                out_next.status = STAT_FULL;
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_inc;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (req.data.value_a[WORD_W-1])
                                out_next.status = STAT_RANGE;
                            else if (count_reg != '0)
                            begin
                                seq_next       = req.data.value_a[SEQ_W-1:0];
                                rd_idx_next    = '0;
                                have_prev_next = 1'b0;
                                hit_next       = 1'b0;
                                out_valid_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            out_next.status = STAT_RANGE;
                        end
                    endcase
                    out_next.word_count = count_next;
                end
            end
            S_SECOND:
            begin
                mem_we              = 1'b1;
                mem_waddr           = count_inc[ADDR_W-1:0];
                mem_wdata           = {1'b0, last_reg};
                count_next          = count_reg + COUNT_W'(2);
                out_next.found      = 1'b0;
                out_next.status     = STAT_OK;
                out_next.word_count = count_next;
                out_valid_next      = 1'b1;
            end
            S_WALK:
            begin
                if (issue)
                begin
                    mem_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + COUNT_W'(1);
                end
                rvalid_next = issue;
                if (rvalid_reg)
                begin
                    if (have_prev_reg)
                        hit_next = hit_reg || match_hit;
                    prev_next      = rd_data_reg;
                    have_prev_next = 1'b1;
                end
                if (walk_done)
                begin
                    out_next.found      = hit_reg || match_hit;
                    out_next.status     = STAT_OK;
                    out_next.word_count = count_reg;
                    out_valid_next      = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rvalid_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rvalid_reg    <= rvalid_next;
            have_prev_reg <= have_prev_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        seq_reg  <= seq_next;
        prev_reg <= prev_next;
        out_reg  <= out_next;
    end

    `NLL_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= COUNT_W'(MAX_WORDS), "word count past capacity")
    `NLL_ASSERT_IMP(a_walk_no_write, state_reg == S_WALK, !mem_we, "RAM write during query walk")
    `NLL_ASSERT_IMP(a_walk_index, state_reg == S_WALK, rd_idx_reg <= count_reg, "walk read past list end")
    `NLL_ASSERT_NXT(a_second_result, state_reg == S_SECOND, out_valid_reg, "range add gave no result")

endmodule
